>>> hw/rtl/integer_to_ascii_converter_macros.svh
// assertion macros for the integer to ascii converter
`ifndef INTEGER_TO_ASCII_CONVERTER_MACROS_SVH
`define INTEGER_TO_ASCII_CONVERTER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ITOA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itoa assertion failed");

`define ITOA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itoa assertion failed");

`else

`define ITOA_ASSERT_NOW(label, ante, cons)

`define ITOA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/itoa_pkg.sv
package itoa_pkg;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h61;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [3:0] MAX_DEC_DIGIT = 4'd9;
  localparam logic [3:0] DIGIT_TEN = 4'd10;

endpackage

>>> hw/rtl/itoa_ifs.sv
interface itoa_in_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] value;
  logic                base_hex;

  modport source (output valid, value, base_hex, input ready);
  modport sink (input valid, value, base_hex, output ready);
endinterface

interface itoa_out_if ();
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, char_code, last, input ready);
  modport sink (input valid, char_code, last, output ready);
endinterface

>>> hw/rtl/integer_to_ascii_converter.sv
// integer to ascii converter
// item_in carries one signed value of VALUE_WIDTH bits and base_hex (0 decimal, 1 hex).
// char_out carries the text of that value, one ascii character per item, most
// significant first, with last set on the final character. negative values get a
// leading '-' and then the digits of the magnitude, in hex as well; the most negative
// value prints as 2^(VALUE_WIDTH-1). zero prints as a single '0'. hex digits are a-f.
// an item passes a negate register, then (VALUE_WIDTH+3)/4 shift-add-3 stages that
// convert four bits each, then a digit count register, from which the serializer loads it.
// the serializer sends one character per cycle while char_out.ready is high (a value
// has up to 11 characters at the default width); the next value loads in the same
// cycle as the handshake on the last character of the one before, so no gap comes
// between values; new values keep entering the pipeline while the serializer is
// busy, until the pipeline fills.
// when char_out stalls the character on it holds, and once the last pipeline stage
// is full the whole pipeline holds and item_in.ready drops; nothing is lost.
// reset (rst, synchronous) empties the pipeline and the serializer; it takes effect
// at the next clock edge, item_in.ready stays low while rst is high, and no items are
// pending after it.
module integer_to_ascii_converter #(
  parameter int VALUE_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  itoa_in_if.sink    item_in,
  itoa_out_if.source char_out
);
  import itoa_pkg::*;

  `include "integer_to_ascii_converter_macros.svh"

  localparam int W    = VALUE_WIDTH;
  localparam int NDIG = (VALUE_WIDTH * 302) / 1000 + 1;
  localparam int DW   = NDIG * 4;
  localparam int IW   = $clog2(NDIG);
  localparam int BPS  = 4;
  localparam int NDD  = (VALUE_WIDTH + BPS - 1) / BPS;

  typedef struct packed {
    logic          neg;
    logic          hex;
    logic [W-1:0]  mag;
    logic [W-1:0]  sh;
    logic [DW-1:0] bcd;
  } cv_t;

  cv_t            cv [NDD+1];
  cv_t            cv_next [NDD+1];
  logic [NDD:0]   cv_vld;
  logic           fin_vld;
  logic           fin_neg;
  logic [DW-1:0]  fin_dig;
  logic [IW-1:0]  fin_top;
  logic [DW-1:0]  fin_dig_next;
  logic [IW-1:0]  fin_top_next;
  logic           busy;
  logic           neg_pend;
  logic [IW-1:0]  idx;
  logic [DW-1:0]  dig;
  logic [3:0]     cur;
  logic           hs;
  logic           done;
  logic           ld;
  logic           en;
  logic [W-1:0]   vu;

  // stage 0: sign and magnitude
  always_comb begin
    vu = W'(item_in.value);
    cv_next[0].neg = vu[W-1];
    cv_next[0].hex = item_in.base_hex;
    cv_next[0].mag = vu[W-1] ? (~vu + 1'b1) : vu;
    cv_next[0].sh  = cv_next[0].mag;
    cv_next[0].bcd = '0;
  end

  // shift-add-3 stages, four bits each
  for (genvar k = 1; k <= NDD; k++) begin : g_dd
    cv_t t;
    always_comb begin
      t = cv[k-1];
      for (int s = 0; s < BPS; s++) begin
        if ((k - 1) * BPS + s < W) begin
          for (int d = 0; d < NDIG; d++) begin
            if (t.bcd[d*4 +: 4] >= 4'd5) begin
              t.bcd[d*4 +: 4] = t.bcd[d*4 +: 4] + 4'd3;
            end
          end
          t.bcd = {t.bcd[DW-2:0], t.sh[W-1]};
          t.sh  = {t.sh[W-2:0], 1'b0};
        end
      end
      cv_next[k] = t;
    end
  end

  // digit select and top digit search
  always_comb begin
    fin_dig_next = cv[NDD].hex ? {{(DW-W){1'b0}}, cv[NDD].mag} : cv[NDD].bcd;
    fin_top_next = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (fin_dig_next[d*4 +: 4] != 4'd0) begin
        fin_top_next = IW'(d);
      end
    end
  end

  assign en            = !fin_vld || ld;
  assign item_in.ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_vld  <= '0;
      fin_vld <= 1'b0;
    end else if (en) begin
      cv_vld  <= {cv_vld[NDD-1:0], item_in.valid};
      fin_vld <= cv_vld[NDD];
    end
  end

  for (genvar k = 0; k <= NDD; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en) begin
        cv[k] <= cv_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_neg <= cv[NDD].neg;
      fin_dig <= fin_dig_next;
      fin_top <= fin_top_next;
    end
  end

  // serializer
  assign cur  = dig[{idx, 2'b00} +: 4];
  assign hs   = busy && char_out.ready;
  assign done = hs && char_out.last;
  assign ld   = fin_vld && (!busy || done);

  assign char_out.valid = busy;
  assign char_out.last  = !neg_pend && (idx == '0);

  always_comb begin
    if (neg_pend) begin
      char_out.char_code = CH_MINUS;
    end else if (cur > MAX_DEC_DIGIT) begin
      char_out.char_code = CH_A + 7'(cur - DIGIT_TEN);
    end else begin
      char_out.char_code = CH_ZERO + 7'(cur);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      neg_pend <= 1'b0;
      idx      <= '0;
    end else if (ld) begin
      busy     <= 1'b1;
      neg_pend <= fin_neg;
      idx      <= fin_top;
    end else if (done) begin
      busy <= 1'b0;
    end else if (hs) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      dig <= fin_dig;
    end
  end

  `ITOA_ASSERT_NOW(a_minus_not_last, busy && neg_pend, !char_out.last)
  `ITOA_ASSERT_NOW(a_load_when_free, ld, !busy || done)
  `ITOA_ASSERT_NEXT(a_fin_holds, fin_vld && !ld, fin_vld)
  `ITOA_ASSERT_NEXT(a_idle_after_last, done && !ld, !busy)

endmodule

>>> bench/integer_to_ascii_converter_tb.sv
`timescale 1ns / 100ps

module integer_to_ascii_converter_tb;
  import itoa_pkg::*;

  localparam int VALUE_WIDTH = 32;
  localparam logic BASE_DEC = 1'b0;
  localparam logic BASE_HEX = 1'b1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } text_char_t;

  logic clk;
  logic rst;

  itoa_in_if #(.W(VALUE_WIDTH)) in_bus ();
  itoa_out_if out_bus ();

  integer_to_ascii_converter #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .item_in(in_bus),
    .char_out(out_bus)
  );

  text_char_t text_q[$];
  int fail_count = 0;
  int cycle_count = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  logic hold_on = 1'b0;
  event hold_start;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // text of one value, most significant character first
  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] v, input logic hex);
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] radix;
    logic [3:0]             digit;
    logic [6:0]             codes[$];
    text_char_t             c;
    neg = v[VALUE_WIDTH-1];
    mag = neg ? (~v + 1'b1) : v;
    radix = (hex == BASE_HEX) ? 16 : 10;
    if (mag == 0) begin
      c.char_code = CH_ZERO;
      c.last = 1'b1;
      text_q.push_back(c);
      return;
    end
    while (mag != 0) begin
      digit = 4'(mag % radix);
      codes.push_front((digit > MAX_DEC_DIGIT) ? CH_A + 7'(digit - DIGIT_TEN)
                                               : CH_ZERO + 7'(digit));
      mag = mag / radix;
    end
    if (neg) begin
      c.char_code = CH_MINUS;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    foreach (codes[i]) begin
      c.char_code = codes[i];
      c.last = (i == codes.size() - 1);
      text_q.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && in_bus.valid && in_bus.ready) begin
      predict_text(in_bus.value, in_bus.base_hex);
    end
  end

  // long receiver hold-off, counted in cycles
  always begin : hold_proc
    @(hold_start);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin : char_check
    text_char_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (text_q.size() == 0) begin
        $error("unexpected item: char_code %h last %b", out_bus.char_code, out_bus.last);
        fail_count++;
      end else begin
        want = text_q.pop_front();
        if (out_bus.char_code !== want.char_code) begin
          $error("char_code expected %h actual %h", want.char_code, out_bus.char_code);
          fail_count++;
        end
        if (out_bus.last !== want.last) begin
          $error("last expected %b actual %b", want.last, out_bus.last);
          fail_count++;
        end
      end
    end
    if (hold_on) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_value(input logic [VALUE_WIDTH-1:0] v, input logic hex);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.value    <= v;
    in_bus.base_hex <= hex;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic wait_text_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (text_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] pick_value(input logic hex);
    logic [VALUE_WIDTH-1:0] p;
    int                     k;
    p = 1;
    case ($urandom_range(0, 4))
      0: pick_value = $urandom;
      1: pick_value = $urandom_range(0, 40);
      2: begin
        // around a change in digit count
        k = (hex == BASE_HEX) ? $urandom_range(0, 7) : $urandom_range(0, 9);
        repeat (k) p = p * ((hex == BASE_HEX) ? 16 : 10);
        pick_value = p + $urandom_range(0, 2) - 1;
      end
      3: pick_value = 32'h7fff_ffff + $urandom_range(0, 2);
      default: pick_value = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1)) pick_value = -pick_value;
  endfunction

  task automatic test_edge_values();
    in_idle_pct = 0;
    out_idle_pct = 0;
    send_value(32'd0, BASE_DEC);
    send_value(32'd0, BASE_HEX);
    send_value(-32'sd1, BASE_DEC);
    send_value(-32'sd1, BASE_HEX);
    send_value(32'h7fff_ffff, BASE_DEC);
    send_value(32'h7fff_ffff, BASE_HEX);
    send_value(32'h8000_0000, BASE_DEC);
    send_value(32'h8000_0000, BASE_HEX);
    send_value(32'd1, BASE_DEC);
    send_value(32'd9, BASE_DEC);
    send_value(32'd10, BASE_DEC);
    send_value(-32'sd10, BASE_DEC);
    send_value(32'd1000000000, BASE_DEC);
    send_value(-32'sd999999999, BASE_DEC);
    send_value(32'd255, BASE_DEC);
    send_value(32'd15, BASE_HEX);
    send_value(32'd16, BASE_HEX);
    send_value(32'h00fe_dcba, BASE_HEX);
    send_value(32'hdead_beef, BASE_HEX);
    send_value(32'h1000_0000, BASE_HEX);
    send_value(32'h0abc_def0, BASE_HEX);
    wait_text_drained();
  endtask

  task automatic test_random_values(input int count, input int in_pct, input int out_pct);
    logic hex;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    repeat (count) begin
      hex = 1'($urandom_range(0, 1));
      send_value(pick_value(hex), hex);
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_output_stall();
    logic hex;
    in_idle_pct = 0;
    out_idle_pct = 0;
    -> hold_start;
    repeat (30) begin
      hex = 1'($urandom_range(0, 1));
      send_value(pick_value(hex), hex);
    end
    wait_text_drained();
  endtask

  initial begin
    rst <= 1'b1;
    in_bus.valid <= 1'b0;
    in_bus.value <= '0;
    in_bus.base_hex <= BASE_DEC;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_values();
    test_random_values(70, 25, 80);
    test_random_values(70, 80, 25);
    test_output_stall();
    test_random_values(50, 0, 0);

    wait_text_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> integer_to_ascii_converter.f
+incdir+hw/rtl
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_ifs.sv
hw/rtl/integer_to_ascii_converter.sv
bench/integer_to_ascii_converter_tb.sv
